// ===== hw/rtl/sge_pkg.sv =====
package sge_pkg;

   localparam int DATA_W = 16;
   localparam int INDEX_W = 10;
   localparam int ELEM_W = 6;
   localparam int RATE_W = 16;
   localparam int VLEN_W = 7;
   localparam int GRAD_W = 24;
   localparam int SIG_W = 17;
   localparam int ERR_W = 18;
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [1:0] ACT_TRAIN = 2'd0;
   localparam logic [1:0] ACT_WR_CENTER = 2'd1;
   localparam logic [1:0] ACT_WR_CONTEXT = 2'd2;
   localparam logic [1:0] ACT_RD_CENTER = 2'd3;

   localparam logic REG_LEARNING_RATE = 1'b0;
   localparam logic REG_VECTOR_LENGTH = 1'b1;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

// ===== hw/rtl/sge_mul.sv =====
module sge_mul (
   input  logic                                 clock,
   input  sge_pkg::mul_req_type                 req,
   output logic signed [sge_pkg::MUL_P_W-1:0]   product
);

   logic signed [sge_pkg::MUL_P_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= sge_pkg::MUL_P_W'(req.a) * sge_pkg::MUL_P_W'(req.b);
   end

   assign product = product_ff;

endmodule

// ===== hw/rtl/sge_ram.sv =====
module sge_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16,
   parameter int AW = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sge_sigmoid.sv =====
module sge_sigmoid #(
   parameter int DOTW = 40,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic signed [DOTW-1:0]            dot,
   output logic [sge_pkg::SIG_W-1:0]         sig
);

   localparam int HALF = SIGMOID_TABLE_DEPTH / 2;
   localparam int TW = $clog2(SIGMOID_TABLE_DEPTH);
   localparam logic signed [63:0] LIMIT = 64'sd30 <<< 24;
   localparam logic signed [63:0] DEPTH_S = 64'(SIGMOID_TABLE_DEPTH);
   localparam logic [63:0] HQ = (64'd1 << 34) / 64'(SIGMOID_TABLE_DEPTH);

   typedef logic [sge_pkg::SIG_W-1:0] tab_type [SIGMOID_TABLE_DEPTH];

   // shift-subtract quotient, evaluated only while the table is built
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic tab_type build_tab();
      tab_type t;
      logic [63:0] term, sum, v, g, den, s;
      for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
         t[i] = '0;
      end
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int n = 1; n <= 16; n++) begin
         term = udiv((term * HQ + (64'd1 << 29)) >> 30, 64'(n));
         if (n[0]) sum = sum - term;
         else sum = sum + term;
      end
      v = sum;
      g = (v * v + (64'd1 << 29)) >> 30;
      for (int m = 0; m < HALF; m++) begin
         den = (64'd1 << 30) + v;
         s = udiv((64'd1 << 46) + (den >> 1), den);
         t[HALF + m] = sge_pkg::SIG_W'(s);
         t[HALF - 1 - m] = sge_pkg::SIG_W'(64'd65536 - s);
         v = (v * g + (64'd1 << 29)) >> 30;
      end
      return t;
   endfunction

   localparam tab_type SIG_TAB = build_tab();

   logic signed [63:0] dot_ext;
   logic signed [63:0] scaled;
   logic signed [63:0] idx_raw;
   logic [TW-1:0] idx;
   logic [sge_pkg::SIG_W-1:0] sig_in;
   logic [sge_pkg::SIG_W-1:0] sig_ff;

   always_comb begin
      dot_ext = 64'(dot);
      scaled = dot_ext * DEPTH_S;
      idx_raw = (scaled >>> 29) + 64'(HALF);
      if (idx_raw < 0) idx = '0;
      else if (idx_raw > 64'(2 * HALF - 1)) idx = TW'(2 * HALF - 1);
      else idx = TW'(idx_raw);
      if (dot_ext > LIMIT) sig_in = sge_pkg::SIG_W'(65536);
      else if (dot_ext < -LIMIT) sig_in = '0;
      else sig_in = SIG_TAB[idx];
   end

   always_ff @(posedge clock) begin
      sig_ff <= sig_in;
   end

   assign sig = sig_ff;

endmodule

// ===== hw/rtl/sgns_embedding_update.sv =====
// Skip-gram negative-sampling update engine. The host fills the center and
// context tables with write beats (action 1 and 2) and reads center elements
// back with action 3. A train beat runs a sequencer around one shared
// registered multiplier: the dot product over the elements in use, then the
// sigmoid, gradient and squared error, then the context update per element,
// and on the last beat of a pair the center update per element, followed by a
// sweep that zeroes the gradient buffer; a positive beat starts with the same
// sweep. A skipped negative goes without the dot product and context update.
// Every beat holds the input until its result has gone to the output
// register, so a new beat is not taken before the last one is through.
// A result that waits on a stalled output holds the input longer. After
// reset the block zeroes the gradient buffer before it takes a beat;
// register writes are taken at any time. Table entries never written read
// as anything.
module sgns_embedding_update #(
   parameter int VOCAB_ENTRIES = 1024,
   parameter int MAX_DIM = 64,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [sge_pkg::RATE_W-1:0]          csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [sge_pkg::INDEX_W-1:0]         req_word_index,
   input  logic [sge_pkg::INDEX_W-1:0]         req_target_index,
   input  logic                                req_is_positive,
   input  logic                                req_last_of_pair,
   input  logic [sge_pkg::ELEM_W-1:0]          req_element_index,
   input  logic signed [sge_pkg::DATA_W-1:0]   req_element_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sge_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [sge_pkg::DATA_W-1:0]          rsp_error_squared,
   output logic                                rsp_skipped,
   output logic                                rsp_pair_done
);

   localparam int TDEPTH = VOCAB_ENTRIES * MAX_DIM;
   localparam int AW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int CW = $clog2(MAX_DIM + 1);
   localparam int GIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DOTW = 33 + CW;
   localparam int DW = sge_pkg::DATA_W;
   localparam int GW = sge_pkg::GRAD_W;
   localparam int PW = sge_pkg::MUL_P_W;
   localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_CLR    = 5'd1;
   localparam logic [4:0] S_TRAIN  = 5'd2;
   localparam logic [4:0] S_DOT_A  = 5'd3;
   localparam logic [4:0] S_DOT_B  = 5'd4;
   localparam logic [4:0] S_DOT_C  = 5'd5;
   localparam logic [4:0] S_SIG    = 5'd6;
   localparam logic [4:0] S_ERR    = 5'd7;
   localparam logic [4:0] S_GRADM  = 5'd8;
   localparam logic [4:0] S_GRADC  = 5'd9;
   localparam logic [4:0] S_SQ     = 5'd10;
   localparam logic [4:0] S_UPD_A  = 5'd11;
   localparam logic [4:0] S_UPD_B  = 5'd12;
   localparam logic [4:0] S_UPD_C  = 5'd13;
   localparam logic [4:0] S_UPD_D  = 5'd14;
   localparam logic [4:0] S_LAST   = 5'd15;
   localparam logic [4:0] S_CEN_A  = 5'd16;
   localparam logic [4:0] S_CEN_B  = 5'd17;
   localparam logic [4:0] S_WR     = 5'd18;
   localparam logic [4:0] S_RD_A   = 5'd19;
   localparam logic [4:0] S_RD_B   = 5'd20;
   localparam logic [4:0] S_FIN    = 5'd21;

   logic [4:0] state_ff, state_in;
   logic [4:0] clr_next_ff, clr_next_in;
   logic [CW-1:0] d_ff, d_in;
   logic [AW-1:0] wbase_ff, wbase_in;
   logic [AW-1:0] tbase_ff, tbase_in;
   logic [1:0] action_ff, action_in;
   logic positive_ff, positive_in;
   logic last_ff, last_in;
   logic skip_ff, skip_in;
   logic signed [DW-1:0] value_ff, value_in;
   logic pair_open_ff, pair_open_in;
   logic [sge_pkg::INDEX_W-1:0] pair_word_ff, pair_word_in;
   logic [sge_pkg::RATE_W-1:0] lr_ff, lr_in;
   logic [sge_pkg::VLEN_W-1:0] vl_ff, vl_in;
   logic signed [DOTW-1:0] dot_ff, dot_in;
   logic signed [sge_pkg::ERR_W-1:0] err_ff, err_in;
   logic signed [sge_pkg::MUL_A_W-1:0] grad_ff, grad_in;
   logic signed [DW-1:0] oc_ff, oc_in;
   logic signed [DW-1:0] ot_ff, ot_in;
   logic signed [GW-1:0] og_ff, og_in;
   logic signed [DW-1:0] rd_ff, rd_in;
   logic [DW-1:0] errsq_ff, errsq_in;
   logic done_ff, done_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_read_ff, rsp_read_in;
   logic [DW-1:0] rsp_errsq_ff, rsp_errsq_in;
   logic rsp_skip_ff, rsp_skip_in;
   logic rsp_done_ff, rsp_done_in;

   logic accept;
   logic [CW-1:0] n_use;
   logic word_ok, target_ok, elem_ok;
   logic [AW-1:0] caddr, taddr;
   logic [GIW-1:0] gaddr;

   logic c_we, c_re, t_we, t_re, g_we, g_re;
   logic [DW-1:0] c_wdata, t_wdata, c_rdata, t_rdata;
   logic [GW-1:0] g_wdata, g_rdata;
   sge_pkg::mul_req_type mreq;
   logic signed [PW-1:0] mprod;
   logic [sge_pkg::SIG_W-1:0] sig;

   logic signed [PW-1:0] prod_rnd;
   logic signed [21:0] upd;
   logic signed [GW+1:0] gsum;
   logic signed [DW+6:0] tsum;
   logic signed [GW:0] csum;
   logic signed [PW-1:0] sq_sum;
   logic [PW-17:0] sq_rnd;

   function automatic logic signed [GW-1:0] sat_grad(input logic signed [GW+1:0] v);
      if (v > (GW+2)'(8388607)) return GW'(8388607);
      else if (v < -(GW+2)'(8388608)) return GW'(-8388608);
      else return GW'(v);
   endfunction

   function automatic logic signed [DW-1:0] sat_tab(input logic signed [GW:0] v);
      if (v > (GW+1)'(32767)) return DW'(32767);
      else if (v < -(GW+1)'(32768)) return DW'(-32768);
      else return DW'(v);
   endfunction

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign n_use = (32'(vl_ff) > MAX_DIM) ? CW'(MAX_DIM) : CW'(vl_ff);
   assign word_ok = (32'(req_word_index) < VOCAB_ENTRIES);
   assign target_ok = (32'(req_target_index) < VOCAB_ENTRIES);
   assign elem_ok = (32'(req_element_index) < MAX_DIM);
   assign caddr = wbase_ff + AW'(d_ff);
   assign taddr = tbase_ff + AW'(d_ff);
   assign gaddr = d_ff[GIW-1:0];

   sge_ram #(.DEPTH(TDEPTH), .WIDTH(DW), .AW(AW)) u_center (
      .clock(clock), .wr_en(c_we), .wr_addr(caddr), .wr_data(c_wdata),
      .rd_en(c_re), .rd_addr(caddr), .rd_data(c_rdata)
   );

   sge_ram #(.DEPTH(TDEPTH), .WIDTH(DW), .AW(AW)) u_context (
      .clock(clock), .wr_en(t_we), .wr_addr(taddr), .wr_data(t_wdata),
      .rd_en(t_re), .rd_addr(taddr), .rd_data(t_rdata)
   );

   sge_ram #(.DEPTH(MAX_DIM), .WIDTH(GW), .AW(GIW)) u_grad (
      .clock(clock), .wr_en(g_we), .wr_addr(gaddr), .wr_data(g_wdata),
      .rd_en(g_re), .rd_addr(gaddr), .rd_data(g_rdata)
   );

   sge_mul u_mul (.clock(clock), .req(mreq), .product(mprod));

   sge_sigmoid #(.DOTW(DOTW), .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
      .clock(clock), .dot(dot_ff), .sig(sig)
   );

   always_comb begin
      prod_rnd = mprod + PW'(64'sd2147483648);
      upd = prod_rnd[PW-1:32];
      gsum = (GW+2)'(og_ff) + (GW+2)'(upd);
      tsum = (DW+7)'(ot_ff) + (DW+7)'(upd);
      csum = (GW+1)'($signed(c_rdata)) + (GW+1)'($signed(g_rdata));
      sq_sum = mprod + PW'(32768);
      sq_rnd = sq_sum[PW-1:16];
   end

   always_comb begin
      state_in = state_ff;
      clr_next_in = clr_next_ff;
      d_in = d_ff;
      wbase_in = wbase_ff;
      tbase_in = tbase_ff;
      action_in = action_ff;
      positive_in = positive_ff;
      last_in = last_ff;
      skip_in = skip_ff;
      value_in = value_ff;
      pair_open_in = pair_open_ff;
      pair_word_in = pair_word_ff;
      lr_in = lr_ff;
      vl_in = vl_ff;
      dot_in = dot_ff;
      err_in = err_ff;
      grad_in = grad_ff;
      oc_in = oc_ff;
      ot_in = ot_ff;
      og_in = og_ff;
      rd_in = rd_ff;
      errsq_in = errsq_ff;
      done_in = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_read_in = rsp_read_ff;
      rsp_errsq_in = rsp_errsq_ff;
      rsp_skip_in = rsp_skip_ff;
      rsp_done_in = rsp_done_ff;
      c_we = 1'b0;
      c_re = 1'b0;
      t_we = 1'b0;
      t_re = 1'b0;
      g_we = 1'b0;
      g_re = 1'b0;
      c_wdata = value_ff;
      t_wdata = value_ff;
      g_wdata = '0;
      mreq.a = sge_pkg::MUL_A_W'($signed(c_rdata));
      mreq.b = sge_pkg::MUL_B_W'($signed(t_rdata));

      if (csr_write) begin
         if (csr_index == sge_pkg::REG_LEARNING_RATE) lr_in = csr_data;
         else vl_in = csr_data[sge_pkg::VLEN_W-1:0];
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               positive_in = req_is_positive;
               last_in = req_last_of_pair;
               value_in = req_element_value;
               skip_in = 1'b0;
               rd_in = '0;
               errsq_in = '0;
               done_in = 1'b0;
               dot_in = '0;
               d_in = '0;
               if (req_action == sge_pkg::ACT_TRAIN) begin
                  wbase_in = AW'(req_word_index) * DIM_A;
                  tbase_in = AW'(req_target_index) * DIM_A;
                  if (word_ok && target_ok) begin
                     skip_in = !req_is_positive && pair_open_ff &&
                               (req_target_index == pair_word_ff);
                     if (req_is_positive) begin
                        pair_open_in = 1'b1;
                        pair_word_in = req_target_index;
                        clr_next_in = S_TRAIN;
                        state_in = S_CLR;
                     end else begin
                        state_in = S_TRAIN;
                     end
                  end else begin
                     state_in = S_FIN;
                  end
               end else begin
                  wbase_in = AW'(req_word_index) * DIM_A + AW'(req_element_index);
                  tbase_in = wbase_in;
                  if (word_ok && elem_ok) begin
                     state_in = (req_action == sge_pkg::ACT_RD_CENTER) ? S_RD_A : S_WR;
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end
         end
         S_CLR: begin
            g_we = 1'b1;
            g_wdata = '0;
            if (d_ff == CW'(MAX_DIM - 1)) begin
               d_in = '0;
               state_in = clr_next_ff;
            end else begin
               d_in = d_ff + CW'(1);
            end
         end
         S_TRAIN: begin
            d_in = '0;
            state_in = skip_ff ? S_LAST : S_DOT_A;
         end
         S_DOT_A: begin
            if (d_ff == n_use) begin
               state_in = S_SIG;
            end else begin
               c_re = 1'b1;
               t_re = 1'b1;
               state_in = S_DOT_B;
            end
         end
         S_DOT_B: begin
            state_in = S_DOT_C;
         end
         S_DOT_C: begin
            dot_in = dot_ff + DOTW'(mprod);
            d_in = d_ff + CW'(1);
            state_in = S_DOT_A;
         end
         S_SIG: begin
            state_in = S_ERR;
         end
         S_ERR: begin
            err_in = (positive_ff ? sge_pkg::ERR_W'(65536) : '0) -
                     $signed({1'b0, sig});
            state_in = S_GRADM;
         end
         S_GRADM: begin
            mreq.a = sge_pkg::MUL_A_W'(lr_ff);
            mreq.b = err_ff;
            state_in = S_GRADC;
         end
         S_GRADC: begin
            grad_in = sge_pkg::MUL_A_W'(mprod);
            mreq.a = sge_pkg::MUL_A_W'(err_ff);
            mreq.b = err_ff;
            state_in = S_SQ;
         end
         S_SQ: begin
            errsq_in = (sq_rnd > (PW-16)'(65535)) ? DW'(65535) : DW'(sq_rnd);
            d_in = '0;
            state_in = S_UPD_A;
         end
         S_UPD_A: begin
            if (d_ff == n_use) begin
               state_in = S_LAST;
            end else begin
               c_re = 1'b1;
               t_re = 1'b1;
               g_re = 1'b1;
               state_in = S_UPD_B;
            end
         end
         S_UPD_B: begin
            oc_in = c_rdata;
            ot_in = t_rdata;
            og_in = g_rdata;
            mreq.a = grad_ff;
            mreq.b = sge_pkg::MUL_B_W'($signed(t_rdata));
            state_in = S_UPD_C;
         end
         S_UPD_C: begin
            g_we = 1'b1;
            g_wdata = sat_grad(gsum);
            mreq.a = grad_ff;
            mreq.b = sge_pkg::MUL_B_W'(oc_ff);
            state_in = S_UPD_D;
         end
         S_UPD_D: begin
            t_we = 1'b1;
            t_wdata = sat_tab((GW+1)'(tsum));
            d_in = d_ff + CW'(1);
            state_in = S_UPD_A;
         end
         S_LAST: begin
            d_in = '0;
            state_in = last_ff ? S_CEN_A : S_FIN;
         end
         S_CEN_A: begin
            if (d_ff == n_use) begin
               d_in = '0;
               pair_open_in = 1'b0;
               done_in = 1'b1;
               clr_next_in = S_FIN;
               state_in = S_CLR;
            end else begin
               c_re = 1'b1;
               g_re = 1'b1;
               state_in = S_CEN_B;
            end
         end
         S_CEN_B: begin
            c_we = 1'b1;
            c_wdata = sat_tab(csum);
            d_in = d_ff + CW'(1);
            state_in = S_CEN_A;
         end
         S_WR: begin
            c_we = (action_ff == sge_pkg::ACT_WR_CENTER);
            t_we = (action_ff == sge_pkg::ACT_WR_CONTEXT);
            state_in = S_FIN;
         end
         S_RD_A: begin
            c_re = 1'b1;
            state_in = S_RD_B;
         end
         S_RD_B: begin
            rd_in = c_rdata;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_read_in = rd_ff;
               rsp_errsq_in = errsq_ff;
               rsp_skip_in = skip_ff;
               rsp_done_in = done_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_next_ff <= S_IDLE;
         d_ff <= '0;
         pair_open_ff <= 1'b0;
         pair_word_ff <= '0;
         lr_ff <= sge_pkg::RATE_W'(1638);
         vl_ff <= sge_pkg::VLEN_W'(64);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_next_ff <= clr_next_in;
         d_ff <= d_in;
         pair_open_ff <= pair_open_in;
         pair_word_ff <= pair_word_in;
         lr_ff <= lr_in;
         vl_ff <= vl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wbase_ff <= wbase_in;
      tbase_ff <= tbase_in;
      action_ff <= action_in;
      positive_ff <= positive_in;
      last_ff <= last_in;
      skip_ff <= skip_in;
      value_ff <= value_in;
      dot_ff <= dot_in;
      err_ff <= err_in;
      grad_ff <= grad_in;
      oc_ff <= oc_in;
      ot_ff <= ot_in;
      og_ff <= og_in;
      rd_ff <= rd_in;
      errsq_ff <= errsq_in;
      done_ff <= done_in;
      rsp_read_ff <= rsp_read_in;
      rsp_errsq_ff <= rsp_errsq_in;
      rsp_skip_ff <= rsp_skip_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_error_squared = rsp_errsq_ff;
   assign rsp_skipped = rsp_skip_ff;
   assign rsp_pair_done = rsp_done_ff;

endmodule

// ===== sim/tb_sgns_embedding_update.sv =====
`timescale 1ns / 100ps

module tb_sgns_embedding_update;

   localparam int VOCAB = 1024;
   localparam int DIM = 64;
   localparam int LUT_HALF = 512;
   localparam longint CYCLE_LIMIT = 6000000;
   localparam int PHASE_ITEMS = 57;
   localparam logic [1:0] A_TRAIN = sge_pkg::ACT_TRAIN;
   localparam logic [1:0] A_WR_CEN = sge_pkg::ACT_WR_CENTER;
   localparam logic [1:0] A_WR_CTX = sge_pkg::ACT_WR_CONTEXT;
   localparam logic [1:0] A_RD_CEN = sge_pkg::ACT_RD_CENTER;

   typedef struct {
      logic [1:0]         action;
      logic [9:0]         word;
      logic [9:0]         target;
      logic               pos;
      logic               last;
      logic [5:0]         elem;
      logic signed [15:0] value;
   } beat_type;

   typedef struct {
      logic signed [15:0] read_value;
      logic [15:0]        err_sq;
      logic               skipped;
      logic               done;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [sge_pkg::RATE_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [sge_pkg::DATA_W-1:0] rsp_read_value;
   logic [sge_pkg::DATA_W-1:0] rsp_error_squared;
   logic rsp_skipped;
   logic rsp_pair_done;

   beat_type cur_beat = '{default: '0};
   logic req_taken = 1'b0;

   beat_type pending_beats[$];
   outcome_type expected_outcomes[$];

   // embedding model state
   shortint center_mem[VOCAB*DIM];
   shortint context_mem[VOCAB*DIM];
   int grad_acc[DIM];
   int unsigned open_target = 0;
   bit pair_is_open = 0;
   int unsigned rate_q = 1638;
   int unsigned vlen_q = 64;
   int sig_lut[2*LUT_HALF];

   // stimulus bookkeeping
   int pool[8] = '{0, 1023, 341, 682, 5, 17, 200, 512};
   int loose_addrs[$];

   longint cycles = 0;
   int mismatches = 0;
   int rsp_count = 0;
   int hold_left = 0;
   bit hold_done = 0;

   sgns_embedding_update u_top (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(cur_beat.action),
      .req_word_index(cur_beat.word),
      .req_target_index(cur_beat.target),
      .req_is_positive(cur_beat.pos),
      .req_last_of_pair(cur_beat.last),
      .req_element_index(cur_beat.elem),
      .req_element_value(cur_beat.value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_error_squared(rsp_error_squared),
      .rsp_skipped(rsp_skipped),
      .rsp_pair_done(rsp_pair_done)
   );

   always #2 clock = ~clock;

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void build_sig_lut();
      longint unsigned hq, term, sum, v, g, den, s;
      hq = (64'd1 << 34) / 64'd1024;
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int n = 1; n <= 16; n++) begin
         term = ((term * hq + (64'd1 << 29)) >> 30) / longint'(n);
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      v = sum;
      g = (v * v + (64'd1 << 29)) >> 30;
      for (int m = 0; m < LUT_HALF; m++) begin
         den = (64'd1 << 30) + v;
         s = ((64'd1 << 46) + (den >> 1)) / den;
         sig_lut[LUT_HALF + m] = int'(s);
         sig_lut[LUT_HALF - 1 - m] = 65536 - int'(s);
         v = (v * g + (64'd1 << 29)) >> 30;
      end
   endfunction

   function automatic int sigmoid_q16(longint dot);
      longint idx;
      if (dot > (longint'(30) <<< 24)) return 65536;
      if (dot < -(longint'(30) <<< 24)) return 0;
      idx = ((dot * 1024) >>> 29) + LUT_HALF;
      idx = clamp(idx, 0, 2*LUT_HALF - 1);
      return sig_lut[idx];
   endfunction

   // advance the embedding state by one accepted beat
   function automatic outcome_type apply_beat(beat_type b);
      outcome_type r;
      int n, cb, tb;
      longint dot, err, grad, sq, oc, ot;
      r = '{default: '0};
      n = (vlen_q > DIM) ? DIM : int'(vlen_q);
      cb = int'(b.word) * DIM;
      tb = int'(b.target) * DIM;
      case (b.action)
         A_WR_CEN: center_mem[cb + b.elem] = b.value;
         A_WR_CTX: context_mem[cb + b.elem] = b.value;
         A_RD_CEN: r.read_value = center_mem[cb + b.elem];
         default: begin
            if (b.pos) begin
               foreach (grad_acc[d]) grad_acc[d] = 0;
               open_target = b.target;
               pair_is_open = 1;
            end
            if (!b.pos && pair_is_open && b.target == open_target) begin
               r.skipped = 1'b1;
            end else begin
               dot = 0;
               for (int d = 0; d < n; d++)
                  dot += longint'(center_mem[cb + d]) * longint'(context_mem[tb + d]);
               err = (b.pos ? 65536 : 0) - longint'(sigmoid_q16(dot));
               grad = longint'(rate_q) * err;
               sq = rnd_shift(err * err, 16);
               r.err_sq = (sq > 65535) ? 16'hFFFF : 16'(sq);
               for (int d = 0; d < n; d++) begin
                  oc = center_mem[cb + d];
                  ot = context_mem[tb + d];
                  grad_acc[d] = int'(clamp(longint'(grad_acc[d]) + rnd_shift(grad * ot, 32),
                                           -8388608, 8388607));
                  context_mem[tb + d] = shortint'(clamp(ot + rnd_shift(grad * oc, 32),
                                                        -32768, 32767));
               end
            end
            if (b.last) begin
               for (int d = 0; d < n; d++)
                  center_mem[cb + d] = shortint'(clamp(longint'(center_mem[cb + d]) +
                                                       grad_acc[d], -32768, 32767));
               foreach (grad_acc[d]) grad_acc[d] = 0;
               pair_is_open = 0;
               r.done = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void add_beat(logic [1:0] action, int word, int target, bit pos,
                                    bit last, int elem, int value);
      beat_type b;
      b.action = action;
      b.word = 10'(word);
      b.target = 10'(target);
      b.pos = pos;
      b.last = last;
      b.elem = 6'(elem);
      b.value = 16'(value);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   function automatic int pick_value();
      if ($urandom_range(99) < 10) return int'($urandom_range(65535));
      return int'($urandom_range(4095)) - 2048;
   endfunction

   function automatic int pick_word();
      return pool[$urandom_range(7)];
   endfunction

   function automatic bit idle_now();
      if (cycles > 20000 && cycles < 60000) return 0;
      return $urandom_range(99) < 6;
   endfunction

   function automatic void add_train(int word, int target, bit pos, bit last);
      add_beat(A_TRAIN, word, target, pos, last, $urandom_range(63),
               int'($urandom_range(65535)));
   endfunction

   function automatic void add_random_phase(int count);
      int made, k, w, t, a, r;
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         if (r < 70) begin
            w = pick_word();
            t = pick_word();
            k = $urandom_range(4);
            add_train(w, t, 1, k == 0);
            for (int j = 1; j <= k; j++)
               add_train(w, ($urandom_range(99) < 15) ? t : pick_word(), 0, j == k);
            made += k + 1;
         end else if (r < 80) begin
            add_train(pick_word(), pick_word(), $urandom_range(1), $urandom_range(1));
            made++;
         end else if (r < 90) begin
            if ($urandom_range(3) == 0) begin
               a = int'($urandom_range(VOCAB*DIM - 1));
               loose_addrs.insert(loose_addrs.size(), a);
               add_beat(A_WR_CEN, a / DIM, $urandom_range(1023), $urandom_range(1),
                        $urandom_range(1), a % DIM, pick_value());
            end else begin
               add_beat($urandom_range(1) ? A_WR_CEN : A_WR_CTX, pick_word(),
                        $urandom_range(1023), $urandom_range(1), $urandom_range(1),
                        $urandom_range(63), pick_value());
            end
            made++;
         end else begin
            if (loose_addrs.size() > 0 && $urandom_range(1)) begin
               a = loose_addrs[$urandom_range(loose_addrs.size() - 1)];
               add_beat(A_RD_CEN, a / DIM, $urandom_range(1023), $urandom_range(1),
                        $urandom_range(1), a % DIM, int'($urandom_range(65535)));
            end else begin
               add_beat(A_RD_CEN, pick_word(), $urandom_range(1023), $urandom_range(1),
                        $urandom_range(1), $urandom_range(63), int'($urandom_range(65535)));
            end
            made++;
         end
      end
   endfunction

   task automatic wait_drained();
      while (pending_beats.size() > 0 || expected_outcomes.size() > 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int unsigned val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= sge_pkg::RATE_W'(val);
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == sge_pkg::REG_LEARNING_RATE) rate_q = val & 32'hFFFF;
      else vlen_q = val & 32'h7F;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // accept side: predict at the edge that takes the beat
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_outcomes.insert(expected_outcomes.size(), apply_beat(cur_beat));
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_beats.size() > 0 && !idle_now()) begin
            cur_beat <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stalls, and one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_count >= 150) begin
         hold_done <= 1;
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_now();
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat at cycle %0d", cycles);
         end else begin
            want = expected_outcomes.pop_front();
            if (want.read_value !== rsp_read_value || want.err_sq !== rsp_error_squared ||
                want.skipped !== rsp_skipped || want.done !== rsp_pair_done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0d: exp %0d %0d %0b %0b got %0d %0d %0b %0b",
                           cycles, want.read_value, want.err_sq, want.skipped, want.done,
                           rsp_read_value, rsp_error_squared, rsp_skipped, rsp_pair_done);
            end
         end
      end
   end

   initial begin
      int unsigned rates[7] = '{65535, 0, 1638, 40000, 3000, 65535, 777};
      int unsigned lens[7] = '{64, 1, 0, 127, 17, 100, 64};
      int v;
      build_sig_lut();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every vector that training touches; words 5, 17 and 200 get rail values
      foreach (pool[i]) begin
         for (int e = 0; e < DIM; e++) begin
            v = (pool[i] == 5) ? 32767 : int'($urandom_range(4095)) - 2048;
            add_beat(A_WR_CEN, pool[i], $urandom_range(1023), $urandom_range(1),
                     $urandom_range(1), e, v);
            v = (pool[i] == 17) ? 32767 : (pool[i] == 200) ? -32768
                                            : int'($urandom_range(4095)) - 2048;
            add_beat(A_WR_CTX, pool[i], $urandom_range(1023), $urandom_range(1),
                     $urandom_range(1), e, v);
         end
      end

      // directed beats
      add_beat(A_RD_CEN, 1023, 0, 0, 0, 63, 0);
      add_beat(A_RD_CEN, 0, 1023, 1, 1, 0, -1);
      add_train(5, 17, 1, 0);
      add_train(5, 17, 0, 0);
      add_train(5, 200, 0, 1);
      add_train(5, 17, 1, 1);
      add_train(0, 341, 0, 1);
      add_train(0, 1023, 1, 0);
      add_train(0, 682, 1, 0);
      add_train(0, 682, 0, 1);
      add_train(1023, 512, 1, 0);
      add_train(1023, 0, 0, 0);
      add_train(1023, 512, 0, 0);
      add_train(1023, 200, 0, 1);
      add_beat(A_WR_CEN, 1023, 0, 0, 0, 63, -32768);
      add_beat(A_WR_CEN, 682, 0, 1, 1, 42, 32767);
      add_beat(A_RD_CEN, 1023, 0, 0, 0, 63, 0);
      add_beat(A_RD_CEN, 682, 0, 0, 0, 42, 0);
      add_beat(A_RD_CEN, 5, 0, 0, 0, 10, 0);
      wait_drained();

      for (int p = 0; p < 7; p++) begin
         write_reg(sge_pkg::REG_LEARNING_RATE, rates[p]);
         write_reg(sge_pkg::REG_VECTOR_LENGTH, lens[p]);
         add_random_phase(PHASE_ITEMS);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
